FILE: rtl/hangul_encoding_detector_macros.svh
// assertion macros used by the checker file of the hangul encoding detector
// no dependencies; included by bare file name
`ifndef HANGUL_ENCODING_DETECTOR_MACROS_SVH
`define HANGUL_ENCODING_DETECTOR_MACROS_SVH

// same-cycle implication, reset is active low
`define HED_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset is active low
`define HED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hed_pkg.sv
// package of the hangul encoding detector: widths, code tables, classification functions
// no dependencies; imported by hed_classify and hangul_encoding_detector
`timescale 1ns / 1ps

package hed_pkg;

    localparam int CNT_W   = 14;
    localparam int LIMIT_W = 15;
    localparam int TLEN_W  = 16;

    typedef logic [15:0]      code_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t SCAN_LIMIT = 14'd10240;
    localparam cnt_t CNT_MAX    = 14'd16383;

    // 65535 / 3
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd21845;
    // floor(x / 3) = (x * 43691) >> 17, exact for 16-bit x
    localparam logic [16:0] DIV3_MUL   = 17'd43691;
    localparam int          DIV3_SHIFT = 17;

    typedef struct packed {
        logic skip;   // shared code, not voted
        logic ks;     // votes wansung, else johab
    } cls_t;

    localparam code_t JOHAB_SET [48] = '{
        16'h8877, 16'h8969, 16'h89a1, 16'h8b71, 16'h8fa1, 16'h9281, 16'h9c61, 16'h9e81,
        16'ha061, 16'ha0f5, 16'ha2a1, 16'ha3a8, 16'ha4e1, 16'ha4e5, 16'ha4f1, 16'ha5c1,
        16'ha7a1, 16'ha8b1, 16'haca1, 16'hace1, 16'hace2, 16'hace3, 16'hace4, 16'hace5,
        16'hace6, 16'hace7, 16'hace8, 16'hace9, 16'hb3a2, 16'hb4a1, 16'hb4a2, 16'hb4e1,
        16'hb4f1, 16'hb4f4, 16'hb541, 16'hb5e1, 16'hb765, 16'hb8e5, 16'hb941, 16'hb9a1,
        16'hb9a5, 16'hb9c1, 16'hc561, 16'hc7a1, 16'hcfa1, 16'hdbad, 16'hdccf, 16'he7e6
    };

    localparam code_t SHARED_SKIP [12] = '{
        16'hbba1, 16'hb7a1, 16'hb4e5, 16'hb7b6, 16'hb4f6, 16'hb8e1,
        16'hb1c1, 16'hbaa1, 16'hbba5, 16'hb6a1, 16'hb6e1, 16'ha1a1
    };

    function automatic logic in_rng(code_t c, code_t a, code_t b);
        return (c >= a) && (c <= b);
    endfunction

    function automatic logic open_rng(code_t c, code_t a, code_t b);
        return (c > a) && (c < b);
    endfunction

    // high byte in h0 .. h0+n-1, low byte in a1 .. fe
    function automatic logic han_block(code_t c, logic [7:0] h0, logic [7:0] n);
        logic [8:0] top;
        top = {1'b0, h0} + {1'b0, n};
        return (c[15:8] >= h0) && ({1'b0, c[15:8]} < top) &&
               (c[7:0] > 8'ha0) && (c[7:0] < 8'hff);
    endfunction

    function automatic logic is_johab_forced(code_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 48; i++) begin
            if (JOHAB_SET[i] == c) hit = 1'b1;
        end
        hit = hit ||
              in_rng(c, 16'hd000, 16'hd3ff) || in_rng(c, 16'hdda1, 16'hde98) ||
              in_rng(c, 16'hdba1, 16'hdbc8) || in_rng(c, 16'hc500, 16'hc5ff) ||
              in_rng(c, 16'hb700, 16'hb7cd) || in_rng(c, 16'hb7cf, 16'hb7ff) ||
              in_rng(c, 16'hda00, 16'hdaff) || in_rng(c, 16'hd9b0, 16'hd9cf) ||
              in_rng(c, 16'hd4b0, 16'hd4cf);
        return hit && (c != 16'hb7e7);
    endfunction

    function automatic logic is_skipped(code_t c);
        logic hit;
        hit = (c >= 16'hb500) && (c < 16'hb5ff) &&
              (c != 16'hb5a5) && (c != 16'hb5e1) && (c != 16'hb541);
        for (int i = 0; i < 12; i++) begin
            if (SHARED_SKIP[i] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic ks_shape(code_t c);
        return open_rng(c, 16'ha1a2, 16'ha1ff) || open_rng(c, 16'ha2a0, 16'ha2e6) ||
               open_rng(c, 16'ha3a0, 16'ha3ff) || open_rng(c, 16'ha4a0, 16'ha4ff) ||
               open_rng(c, 16'ha5a0, 16'ha5f9) || open_rng(c, 16'ha6a0, 16'ha6e5) ||
               open_rng(c, 16'ha7a0, 16'ha7f0) || open_rng(c, 16'ha8a0, 16'ha8ff) ||
               open_rng(c, 16'ha9a0, 16'ha9ff) || open_rng(c, 16'haaa0, 16'haaf4) ||
               open_rng(c, 16'haba0, 16'habf7) || open_rng(c, 16'haca0, 16'hacc2) ||
               open_rng(c, 16'hacd0, 16'hacf2) || (c == 16'haec2) ||
               open_rng(c, 16'hadd0, 16'hadff) ||
               han_block(c, 8'hb0, 8'd16) || han_block(c, 8'hc0, 8'd9) ||
               (c == 16'hb8ae) || (c == 16'hb7e7) ||
               han_block(c, 8'hca, 8'd6) || han_block(c, 8'hd0, 8'd16) ||
               han_block(c, 8'he0, 8'd16) || han_block(c, 8'hf0, 8'd14);
    endfunction

endpackage

FILE: rtl/hed_classify.sv
// code classifier of the hangul encoding detector: skip test and wansung/johab vote
// depends on hed_pkg
`timescale 1ns / 1ps

module hed_classify (
    input  hed_pkg::code_t code,
    output hed_pkg::cls_t  cls
);
    import hed_pkg::*;

    always_comb begin
        cls.skip = is_skipped(code);
        cls.ks   = ks_shape(code) && !is_johab_forced(code);
    end

endmodule

FILE: rtl/hangul_encoding_detector.sv
// hangul encoding detector: votes wansung (KS) against johab (KSSM) over a byte stream
// the last byte passes through the input register, and its result is written into the output register
// throughput: one byte per cycle; a last byte waits only while the previous result is not taken
// reset (aresetn low, synchronous) clears the scan counts and both valid flags, and sets the limit to 21845
// depends on hed_pkg and hed_classify
`timescale 1ns / 1ps

module hangul_encoding_detector (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: text_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // text_byte
    input  logic        s_tlast,    // last_byte
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // ks_bytes[13:0], kssm_bytes[27:14], other_bytes[41:28], zeros
    output logic        m_tuser     // is_ks
);
    import hed_pkg::*;

    // early stop threshold, text_length / 3 taken at the write
    logic [LIMIT_W-1:0] limit_reg;
    logic [32:0]        div3_prod;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scan state
    logic       lead_pend_reg, lead_pend_next;
    logic [7:0] lead_reg,      lead_next;
    cnt_t       ks_reg,        ks_next;
    cnt_t       kssm_reg,      kssm_next;
    cnt_t       cons_reg,      cons_next;
    logic       fin_reg,       fin_next;

    // output register
    logic       out_vld_reg;
    cnt_t       out_ks_reg, out_kssm_reg, out_other_reg;
    logic       out_isks_reg;

    logic       advance;
    code_t      code;
    cls_t       cls;
    cnt_t       cons_inc, ks_inc, kssm_inc;
    cnt_t       pair_sum;
    logic [14:0] coded;
    cnt_t       other;

    assign cfg_ready = 1'b1;
    assign div3_prod = {17'd0, cfg_data} * {16'd0, DIV3_MUL};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= div3_prod[DIV3_SHIFT +: LIMIT_W];
        end
    end

    // a byte in the input register moves on unless it would produce a result
    // while the previous result still waits
    assign advance  = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // code formed from the pending lead byte and the current byte
    assign code = {lead_reg, in_byte_reg};

    hed_classify u_classify (
        .code (code),
        .cls  (cls)
    );

    // byte count saturates; code counts stay far below their width
    assign cons_inc = (cons_reg == CNT_MAX) ? cons_reg : cons_reg + 14'd1;
    assign ks_inc   = ks_reg + 14'd1;
    assign kssm_inc = kssm_reg + 14'd1;

    always_comb begin
        lead_pend_next = lead_pend_reg;
        lead_next      = lead_reg;
        ks_next        = ks_reg;
        kssm_next      = kssm_reg;
        cons_next      = cons_reg;
        fin_next       = fin_reg;
        if (!fin_reg) begin
            cons_next = cons_inc;
            if (!lead_pend_reg) begin
                if (in_byte_reg[7]) begin
                    // lead byte past the scan limit ends counting
                    if (cons_inc > SCAN_LIMIT) begin
                        fin_next = 1'b1;
                    end else if (!in_last_reg) begin
                        lead_pend_next = 1'b1;
                        lead_next      = in_byte_reg;
                    end
                end
            end else begin
                lead_pend_next = 1'b0;
                lead_next      = 8'd0;
                if (!cls.skip) begin
                    if (cls.ks) begin
                        ks_next = ks_inc;
                        if ({1'b0, ks_inc} >= limit_reg) fin_next = 1'b1;
                    end else begin
                        kssm_next = kssm_inc;
                        if ({1'b0, kssm_inc} >= limit_reg) fin_next = 1'b1;
                    end
                end
            end
        end
    end

    // result from the updated counts
    assign pair_sum = ks_next + kssm_next;
    assign coded    = {pair_sum, 1'b0};
    assign other    = ({1'b0, cons_next} >= coded) ?
                      cnt_t'({1'b0, cons_next} - coded) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pend_reg <= 1'b0;
            lead_reg      <= 8'd0;
            ks_reg        <= '0;
            kssm_reg      <= '0;
            cons_reg      <= '0;
            fin_reg       <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                // end of text: back to the start state
                lead_pend_reg <= 1'b0;
                lead_reg      <= 8'd0;
                ks_reg        <= '0;
                kssm_reg      <= '0;
                cons_reg      <= '0;
                fin_reg       <= 1'b0;
            end else begin
                lead_pend_reg <= lead_pend_next;
                lead_reg      <= lead_next;
                ks_reg        <= ks_next;
                kssm_reg      <= kssm_next;
                cons_reg      <= cons_next;
                fin_reg       <= fin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_ks_reg    <= {ks_next[CNT_W-2:0], 1'b0};
            out_kssm_reg  <= {kssm_next[CNT_W-2:0], 1'b0};
            out_other_reg <= other;
            // ties go to wansung
            out_isks_reg  <= (ks_next >= kssm_next);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_other_reg, out_kssm_reg, out_ks_reg};
    assign m_tuser  = out_isks_reg;

endmodule

FILE: rtl/hed_checker.sv
// port checker of the hangul encoding detector, bound to the top level
// depends on hangul_encoding_detector_macros.svh
`timescale 1ns / 1ps
`include "hangul_encoding_detector_macros.svh"

module hed_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    `HED_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `HED_ASSERT_NOW(a_decision, aclk, aresetn, m_tvalid, m_tuser == (m_tdata[13:0] >= m_tdata[27:14]), "decision disagrees with counts")
    `HED_ASSERT_NOW(a_even_counts, aclk, aresetn, m_tvalid, !m_tdata[0] && !m_tdata[14], "code byte counts must be even")
    `HED_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[47:42] == 6'd0, "result padding not zero")

endmodule

bind hangul_encoding_detector hed_checker u_hed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
